// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define I128_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I128_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/i128_pkg.sv
// Package for the 128-bit integer ALU: commands, widths and stage records.
`default_nettype none
package i128_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned CMD_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_EQ  = 4'd3,
    CMD_NE  = 4'd4,
    CMD_GT  = 4'd5,
    CMD_GE  = 4'd6,
    CMD_LT  = 4'd7,
    CMD_LE  = 4'd8
  } cmd_t;

  // After the partial-product stage.
  typedef struct packed {
    logic              is_mul;
    logic [WORD_W-1:0] res_hi;
    logic [WORD_W-1:0] res_lo;
    logic              flag;
    logic [WORD_W-1:0] ll;
    logic [WORD_W-1:0] lh;
    logic [WORD_W-1:0] hl;
    logic [WORD_W-1:0] hh;
    logic [WORD_W-1:0] c1_ll;
    logic [HALF_W-1:0] c1_x1;
    logic [HALF_W-1:0] c1_x2;
    logic [WORD_W-1:0] c2_ll;
    logic [HALF_W-1:0] c2_x1;
    logic [HALF_W-1:0] c2_x2;
  } s1_t;

  // After the first reduction stage.
  typedef struct packed {
    logic              is_mul;
    logic [WORD_W-1:0] res_hi;
    logic [WORD_W-1:0] res_lo;
    logic              flag;
    logic [WORD_W-1:0] mul_lo;
    logic [1:0]        mid_hi;
    logic [WORD_W-1:0] hsum;
    logic [WORD_W-1:0] cross1;
    logic [WORD_W-1:0] cross2;
  } s2_t;

endpackage
`default_nettype wire

// File: rtl/core/i128_front.sv
// First stage: add/sub, compare and 32x32 partial products.
`default_nettype none
module i128_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            valid_i,
  input  wire logic [i128_pkg::CMD_W-1:0]      command,
  input  wire logic signed [i128_pkg::WORD_W-1:0] a_high,
  input  wire logic [i128_pkg::WORD_W-1:0]     a_low,
  input  wire logic signed [i128_pkg::WORD_W-1:0] b_high,
  input  wire logic [i128_pkg::WORD_W-1:0]     b_low,
  output logic                                 valid_o,
  output i128_pkg::s1_t                        s1_o
);
  import i128_pkg::*;

  logic                valid_r;
  s1_t                 s1_r;
  s1_t                 s1_nxt;
  logic [2*WORD_W-1:0] a_full;
  logic [2*WORD_W-1:0] b_full;
  logic [2*WORD_W-1:0] sum;
  logic                eq;
  logic                lt;

  always_comb begin
    a_full = {a_high, a_low};
    b_full = {b_high, b_low};
    eq = (a_high == b_high) && (a_low == b_low);
    lt = (a_high < b_high) || ((a_high == b_high) && (a_low < b_low));
    sum = '0;
    s1_nxt = '0;

    // al * bl, full 128-bit product pieces
    s1_nxt.ll = WORD_W'(a_low[HALF_W-1:0]) * WORD_W'(b_low[HALF_W-1:0]);
    s1_nxt.lh = WORD_W'(a_low[HALF_W-1:0]) * WORD_W'(b_low[WORD_W-1:HALF_W]);
    s1_nxt.hl = WORD_W'(a_low[WORD_W-1:HALF_W]) * WORD_W'(b_low[HALF_W-1:0]);
    s1_nxt.hh = WORD_W'(a_low[WORD_W-1:HALF_W]) * WORD_W'(b_low[WORD_W-1:HALF_W]);
    // al * bh, low 64 bits only
    s1_nxt.c1_ll = WORD_W'(a_low[HALF_W-1:0]) * WORD_W'(b_high[HALF_W-1:0]);
    s1_nxt.c1_x1 = a_low[HALF_W-1:0] * b_high[WORD_W-1:HALF_W];
    s1_nxt.c1_x2 = a_low[WORD_W-1:HALF_W] * b_high[HALF_W-1:0];
    // ah * bl, low 64 bits only
    s1_nxt.c2_ll = WORD_W'(a_high[HALF_W-1:0]) * WORD_W'(b_low[HALF_W-1:0]);
    s1_nxt.c2_x1 = a_high[HALF_W-1:0] * b_low[WORD_W-1:HALF_W];
    s1_nxt.c2_x2 = a_high[WORD_W-1:HALF_W] * b_low[HALF_W-1:0];

    case (cmd_t'(command))
      CMD_ADD: sum = a_full + b_full;
      CMD_SUB: sum = a_full - b_full;
      CMD_MUL: s1_nxt.is_mul = 1'b1;
      CMD_EQ:  s1_nxt.flag = eq;
      CMD_NE:  s1_nxt.flag = !eq;
      CMD_GT:  s1_nxt.flag = !(lt || eq);
      CMD_GE:  s1_nxt.flag = !lt;
      CMD_LT:  s1_nxt.flag = lt;
      CMD_LE:  s1_nxt.flag = lt || eq;
      default: s1_nxt.flag = 1'b0;
    endcase
    s1_nxt.res_hi = sum[2*WORD_W-1:WORD_W];
    s1_nxt.res_lo = sum[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign valid_o = valid_r;
  assign s1_o    = s1_r;

endmodule
`default_nettype wire

// File: rtl/core/i128_reduce.sv
// Second stage: fold the partial products into the low word and high terms.
`default_nettype none
module i128_reduce (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    valid_i,
  input  wire i128_pkg::s1_t s1_i,
  output logic         valid_o,
  output i128_pkg::s2_t s2_o
);
  import i128_pkg::*;

  logic              valid_r;
  s2_t               s2_r;
  s2_t               s2_nxt;
  logic [HALF_W+1:0] mid;
  logic [HALF_W-1:0] x1_sum;
  logic [HALF_W-1:0] x2_sum;

  always_comb begin
    mid = (HALF_W+2)'(s1_i.ll[WORD_W-1:HALF_W]) + (HALF_W+2)'(s1_i.lh[HALF_W-1:0])
        + (HALF_W+2)'(s1_i.hl[HALF_W-1:0]);
    x1_sum = s1_i.c1_x1 + s1_i.c1_x2;
    x2_sum = s1_i.c2_x1 + s1_i.c2_x2;

    s2_nxt.is_mul = s1_i.is_mul;
    s2_nxt.res_hi = s1_i.res_hi;
    s2_nxt.res_lo = s1_i.res_lo;
    s2_nxt.flag   = s1_i.flag;
    s2_nxt.mul_lo = {mid[HALF_W-1:0], s1_i.ll[HALF_W-1:0]};
    s2_nxt.mid_hi = mid[HALF_W+1:HALF_W];
    s2_nxt.hsum   = s1_i.hh + WORD_W'(s1_i.lh[WORD_W-1:HALF_W])
                  + WORD_W'(s1_i.hl[WORD_W-1:HALF_W]);
    s2_nxt.cross1 = s1_i.c1_ll + {x1_sum, {HALF_W{1'b0}}};
    s2_nxt.cross2 = s1_i.c2_ll + {x2_sum, {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign valid_o = valid_r;
  assign s2_o    = s2_r;

endmodule
`default_nettype wire

// File: rtl/core/i128_out.sv
// Final stage: finish the product high word, select the result, output register.
`default_nettype none
`include "assert_macros.svh"
module i128_out (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                valid_i,
  input  wire i128_pkg::s2_t                       s2_i,
  output logic                                     valid_o,
  output logic signed [i128_pkg::WORD_W-1:0]       result_high,
  output logic [i128_pkg::WORD_W-1:0]              result_low,
  output logic                                     compare_true
);
  import i128_pkg::*;

  logic              valid_r;
  logic [WORD_W-1:0] res_hi_r;
  logic [WORD_W-1:0] res_lo_r;
  logic              flag_r;
  logic [WORD_W-1:0] res_hi_nxt;
  logic [WORD_W-1:0] res_lo_nxt;
  logic [WORD_W-1:0] mul_hi;

  always_comb begin
    mul_hi = s2_i.hsum + WORD_W'(s2_i.mid_hi) + s2_i.cross1 + s2_i.cross2;
    if (s2_i.is_mul) begin
      res_hi_nxt = mul_hi;
      res_lo_nxt = s2_i.mul_lo;
    end else begin
      res_hi_nxt = s2_i.res_hi;
      res_lo_nxt = s2_i.res_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_hi_r <= res_hi_nxt;
      res_lo_r <= res_lo_nxt;
      flag_r   <= s2_i.flag;
    end
  end

  assign valid_o      = valid_r;
  assign result_high  = res_hi_r;
  assign result_low   = res_lo_r;
  assign compare_true = flag_r;

  `I128_ASSERT_IMP(a_cmp_zero, valid_r && flag_r, (res_hi_r | res_lo_r) == '0, "compare word nonzero")
  `I128_ASSERT_NXT(a_mul_no_flag, en && valid_i && s2_i.is_mul, !flag_r, "multiply raised flag")
  `I128_ASSERT_NXT(a_hold, !en && valid_r, $stable({res_hi_r, res_lo_r, flag_r}), "held word changed")

endmodule
`default_nettype wire

// File: rtl/core/int128_alu.sv
// An accepted input word passes the front, reduce and out stage registers before out_valid.
// Throughput: one word per cycle while no output stall holds the pipeline; all three stages advance together.
// A stall on the output while out_valid is high freezes the whole pipeline and raises in_stall.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`default_nettype none
module int128_alu (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [i128_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [i128_pkg::WORD_W-1:0]  in_a_high,
  input  wire logic [i128_pkg::WORD_W-1:0]         in_a_low,
  input  wire logic signed [i128_pkg::WORD_W-1:0]  in_b_high,
  input  wire logic [i128_pkg::WORD_W-1:0]         in_b_low,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [i128_pkg::WORD_W-1:0]       out_result_high,
  output logic [i128_pkg::WORD_W-1:0]              out_result_low,
  output logic                                     out_compare_true
);
  import i128_pkg::*;

  logic adv;
  logic s1_valid;
  logic s2_valid;
  s1_t  s1;
  s2_t  s2;

  // advance unless a finished word is waiting on a stalled sink
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  i128_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_valid),
    .command (in_command),
    .a_high  (in_a_high),
    .a_low   (in_a_low),
    .b_high  (in_b_high),
    .b_low   (in_b_low),
    .valid_o (s1_valid),
    .s1_o    (s1)
  );

  i128_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  i128_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .valid_i      (s2_valid),
    .s2_i         (s2),
    .valid_o      (out_valid),
    .result_high  (out_result_high),
    .result_low   (out_result_low),
    .compare_true (out_compare_true)
  );

endmodule
`default_nettype wire

// File: verif/int128_alu_tb.sv
// Testbench for the 128-bit integer ALU: directed and random words against a predictor.
`timescale 1ns / 100ps
module int128_alu_tb;
  import i128_pkg::*;

  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned PIPE_LATENCY   = 3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  localparam logic [WORD_W-1:0] W_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [WORD_W-1:0] W_ONE  = 64'h0000_0000_0000_0001;
  localparam logic [WORD_W-1:0] W_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] W_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] W_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [WORD_W-1:0] high;
    logic [WORD_W-1:0] low;
    logic              flag;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = CMD_ADD;
  logic signed [WORD_W-1:0] in_a_high = '0;
  logic [WORD_W-1:0]        in_a_low = '0;
  logic signed [WORD_W-1:0] in_b_high = '0;
  logic [WORD_W-1:0]        in_b_low = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_result_high;
  logic [WORD_W-1:0]        out_result_low;
  logic                     out_compare_true;

  alu_result_t answer_q[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  int128_alu u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_a_high        (in_a_high),
    .in_a_low         (in_a_low),
    .in_b_high        (in_b_high),
    .in_b_low         (in_b_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_high  (out_result_high),
    .out_result_low   (out_result_low),
    .out_compare_true (out_compare_true)
  );

  always #6 clk = ~clk;

  // Full 128-bit arithmetic; signed compare of the joined words matches
  // signed-high then unsigned-low ordering.
  function automatic alu_result_t int128_compute(logic [CMD_W-1:0] cmd,
                                                 logic [WORD_W-1:0] ah, logic [WORD_W-1:0] al,
                                                 logic [WORD_W-1:0] bh, logic [WORD_W-1:0] bl);
    logic [2*WORD_W-1:0] a;
    logic [2*WORD_W-1:0] b;
    logic [2*WORD_W-1:0] r;
    alu_result_t         ans;
    a = {ah, al};
    b = {bh, bl};
    r = '0;
    ans.flag = 1'b0;
    case (cmd)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = a * b;
      CMD_EQ:  ans.flag = (a == b);
      CMD_NE:  ans.flag = (a != b);
      CMD_GT:  ans.flag = ($signed(a) > $signed(b));
      CMD_GE:  ans.flag = ($signed(a) >= $signed(b));
      CMD_LT:  ans.flag = ($signed(a) < $signed(b));
      CMD_LE:  ans.flag = ($signed(a) <= $signed(b));
      default: ;
    endcase
    ans.high = r[2*WORD_W-1:WORD_W];
    ans.low  = r[WORD_W-1:0];
    return ans;
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return W_ZERO;
      1:       return W_ONES;
      2:       return W_MIN;
      3:       return W_MAX;
      4:       return W_ONE;
      5:       return WORD_W'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] ah, logic [WORD_W-1:0] al,
                           logic [WORD_W-1:0] bh, logic [WORD_W-1:0] bl);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_a_high  <= ah;
    in_a_low   <= al;
    in_b_high  <= bh;
    in_b_low   <= bl;
    do @(posedge clk); while (in_stall);
    answer_q.push_back(int128_compute(cmd, ah, al, bh, bl));
  endtask

  task automatic send_random();
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] ah;
    logic [WORD_W-1:0] al;
    logic [WORD_W-1:0] bh;
    logic [WORD_W-1:0] bl;
    if ($urandom_range(0, 9) != 0) cmd = CMD_W'($urandom_range(CMD_ADD, CMD_LE));
    else cmd = CMD_W'($urandom_range(CMD_LE + 1, 2**CMD_W - 1));
    ah = pick_word();
    al = pick_word();
    bh = pick_word();
    bl = pick_word();
    // Tie the high words often so compares reach the low-word ordering.
    if ($urandom_range(0, 3) == 0) begin
      bh = ah;
      if ($urandom_range(0, 1) == 0) bl = al;
    end
    send_word(cmd, ah, al, bh, bl);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_add_sub_edges();
    send_word(CMD_ADD, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
    send_word(CMD_ADD, W_ZERO, W_ONES, W_ZERO, W_ONE);
    send_word(CMD_ADD, W_MAX, W_ONES, W_ZERO, W_ONE);
    send_word(CMD_SUB, W_ZERO, W_ZERO, W_ZERO, W_ONE);
    send_word(CMD_SUB, W_MIN, W_ZERO, W_ZERO, W_ONE);
    send_word(CMD_SUB, W_MAX, 64'h1234_5678_9ABC_DEF0, W_ONES, 64'h1234_5678_9ABC_DEF0);
  endtask

  task automatic test_multiply_edges();
    send_word(CMD_MUL, W_ONES, W_ONES, W_ONES, W_ONES);
    send_word(CMD_MUL, W_MIN, W_ZERO, W_ONES, W_ONES);
    send_word(CMD_MUL, W_ZERO, W_ONES, W_ZERO, W_ONES);
    send_word(CMD_MUL, W_ONES, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0005,
              64'hFEDC_BA98_7654_3210);
  endtask

  task automatic test_compare_edges();
    send_word(CMD_EQ, W_MIN, W_ONES, W_MIN, W_ONES);
    send_word(CMD_EQ, W_ZERO, W_ONE, W_ZERO, W_ZERO);
    send_word(CMD_NE, W_MAX, W_ZERO, W_MAX, W_ONE);
    send_word(CMD_GT, W_ONES, W_ZERO, W_ZERO, W_ZERO);
    send_word(CMD_GE, W_ONE, W_MIN, W_ONE, W_MAX);
    send_word(CMD_LT, W_MIN, W_ZERO, W_MAX, W_ONES);
    send_word(CMD_LE, W_ONES, W_ONES, W_ONES, W_ONES);
  endtask

  task automatic test_unknown_commands();
    logic [CMD_W-1:0] code;
    for (int c = CMD_LE + 1; c < 2**CMD_W; c++) begin
      code = CMD_W'(c);
      send_word(code, W_MAX, W_ONES, W_ONES, 64'hA5A5_5A5A_F00F_0FF0);
    end
  endtask

  task automatic test_random_mix(int unsigned count);
    repeat (count) send_random();
  endtask

  // Hold both sides busy so words go through back to back.
  task automatic test_back_to_back(int unsigned count);
    calm = 1'b1;
    repeat (count) send_random();
    calm = 1'b0;
  endtask

  task automatic test_pause_and_drain(int unsigned count);
    repeat (count / 2) send_random();
    stop_sending();
    repeat (count - count / 2) send_random();
  endtask

  initial begin : stall_driver
    int unsigned hold;
    bit          stall_now;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else begin
        stall_now = !calm && ($urandom_range(0, 3) == 0);
        hold = stall_now ? idle_len() : $urandom_range(0, 8);
        out_stall <= stall_now;
      end
    end
  end

  always @(posedge clk) begin : check_results
    alu_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("result word arrived with nothing pending");
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (out_result_high !== want.high) begin
          $error("result_high: expected %h, got %h", want.high, out_result_high);
          fail_count++;
        end
        if (out_result_low !== want.low) begin
          $error("result_low: expected %h, got %h", want.low, out_result_low);
          fail_count++;
        end
        if (out_compare_true !== want.flag) begin
          $error("compare_true: expected %b, got %b", want.flag, out_compare_true);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_add_sub_edges();
    test_multiply_edges();
    test_compare_edges();
    test_unknown_commands();
    test_random_mix(500);
    test_back_to_back(150);
    test_pause_and_drain(200);
    stop_sending();
    repeat (PIPE_LATENCY + 2) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
